// File: src/accel_tilt_angles_macros.svh
// Assertion macros shared by the tilt angle checker.
`ifndef ACCEL_TILT_ANGLES_MACROS_SVH
`define ACCEL_TILT_ANGLES_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define ATA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("accel_tilt_angles: assertion failed");

// Next-cycle implication, sampled on clk and switched off during reset.
`define ATA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("accel_tilt_angles: assertion failed");

`endif

// File: src/ata_pkg.sv
// Types, widths and constants of the accelerometer tilt angle block.
package ata_pkg;

	// Digit steps of the square root: two radicand bits per step, 62-bit radicand.
	localparam int SQ_STEPS = 31;
	localparam int RAD_W    = 62;
	localparam int REM_W    = 33;
	localparam int ROOT_W   = 31;
	// CORDIC datapath widths.
	localparam int CW       = 36;
	localparam int ZW       = 33;
	localparam int ATAN_LEN = 24;
	// 180/pi in Q24.
	localparam logic [29:0] DEG_PER_RAD = 30'd961263669;
	localparam int PROD_W   = 62;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] pitch_deg;
		logic signed [15:0] roll_deg;
		logic signed [15:0] yaw_deg;
	} angle_t;

	// One lane of the square root chain.
	typedef struct packed {
		logic [RAD_W-1:0]   rad;
		logic [REM_W-1:0]   rem;
		logic [ROOT_W-1:0]  root;
		logic signed [15:0] num;
		logic               zero;
	} sqrt_lane_t;

	// One lane of the CORDIC chain.
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 num_pos;
		logic                 num_neg;
		logic                 zero;
	} cordic_lane_t;

	// atan(2^-i) in radians, Q2.30.
	function automatic logic signed [ZW-1:0] atan_q30(input int unsigned i);
		logic signed [ZW-1:0] a;
		unique case (i)
			0:  a = 33'sh03243F6A8;
			1:  a = 33'sh01DAC6705;
			2:  a = 33'sh00FADBAFC;
			3:  a = 33'sh007F56EA6;
			4:  a = 33'sh003FEAB76;
			5:  a = 33'sh001FFD55B;
			6:  a = 33'sh000FFFAAA;
			7:  a = 33'sh0007FFF55;
			8:  a = 33'sh0003FFFEA;
			9:  a = 33'sh0001FFFFD;
			10: a = 33'sh0000FFFFF;
			11: a = 33'sh00007FFFF;
			12: a = 33'sh00003FFFF;
			13: a = 33'sh00001FFFF;
			14: a = 33'sh00000FFFF;
			15: a = 33'sh000007FFF;
			16: a = 33'sh000003FFF;
			17: a = 33'sh000001FFF;
			18: a = 33'sh000000FFF;
			19: a = 33'sh0000007FF;
			20: a = 33'sh0000003FF;
			21: a = 33'sh0000001FF;
			22: a = 33'sh0000000FF;
			23: a = 33'sh00000007F;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// File: src/ata_sqrt_cell.sv
// One digit step of the pipelined integer square root.
module ata_sqrt_cell (
	input  logic               clk,
	input  logic               en,
	input  ata_pkg::sqrt_lane_t d,
	output ata_pkg::sqrt_lane_t q
);
	import ata_pkg::*;

	logic [REM_W+1:0] rem_ext;
	logic [REM_W+1:0] trial;
	logic             ge;
	sqrt_lane_t       nxt;

	// Bring down two radicand bits and try the next root bit.
	always_comb begin
		rem_ext  = {d.rem, d.rad[RAD_W-1 -: 2]};
		trial    = {2'b00, d.root, 2'b01};
		ge       = (rem_ext >= trial);
		nxt      = d;
		nxt.rad  = {d.rad[RAD_W-3:0], 2'b00};
		nxt.rem  = ge ? REM_W'(rem_ext - trial) : rem_ext[REM_W-1:0];
		nxt.root = {d.root[ROOT_W-2:0], ge};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end
endmodule

// File: src/ata_cordic_cell.sv
// One vectoring step of the pipelined CORDIC arctangent.
module ata_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic                 clk,
	input  logic                 en,
	input  ata_pkg::cordic_lane_t d,
	output ata_pkg::cordic_lane_t q
);
	import ata_pkg::*;

	localparam logic signed [ZW-1:0] ANG = atan_q30(STEP);

	logic signed [CW-1:0] dx;
	logic signed [CW-1:0] dy;
	cordic_lane_t         nxt;

	// Rotate towards the x axis and collect the angle.
	always_comb begin
		dx  = d.y >>> STEP;
		dy  = d.x >>> STEP;
		nxt = d;
		if (!d.y[CW-1]) begin
			nxt.x = d.x + dx;
			nxt.y = d.y - dy;
			nxt.z = d.z + ANG;
		end else begin
			nxt.x = d.x - dx;
			nxt.y = d.y + dy;
			nxt.z = d.z - ANG;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end
endmodule

// File: src/ata_post.sv
// Conversion of a CORDIC angle to rounded, saturated degrees.
module ata_post #(
	parameter int ANGLE_FRAC_BITS = 8
) (
	input  logic                 clk,
	input  logic                 en,
	input  ata_pkg::cordic_lane_t d,
	output logic signed [15:0]   angle_s2
);
	import ata_pkg::*;

	localparam int SH      = 54 - ANGLE_FRAC_BITS;
	localparam int RIGHT_I = 90 << ANGLE_FRAC_BITS;
	localparam logic [PROD_W-1:0] RIGHT_P = PROD_W'(RIGHT_I);
	localparam logic [PROD_W-1:0] HALF    = PROD_W'(1) << (SH - 1);
	localparam logic signed [20:0] RIGHT_S = 21'(RIGHT_I);

	logic [31:0]        zabs;
	logic [PROD_W-1:0]  prod_s1;
	logic               neg_s1;
	logic               zero_s1;
	logic               pos_s1;
	logic               nneg_s1;
	logic [PROD_W-1:0]  rnd;
	logic [19:0]        mag;
	logic signed [20:0] res;
	logic signed [15:0] sat;

	// First stage: magnitude of the angle times 180/pi.
	assign zabs = d.z[ZW-1] ? 32'(-d.z) : 32'(d.z);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_W'(zabs) * PROD_W'(DEG_PER_RAD);
			neg_s1  <= d.z[ZW-1];
			zero_s1 <= d.zero;
			pos_s1  <= d.num_pos;
			nneg_s1 <= d.num_neg;
		end
	end

	// Second stage: round, limit to a right angle, restore the sign (zero radius: a signed right angle or 0), saturate.
	always_comb begin
		rnd = (prod_s1 + HALF) >> SH;
		mag = (rnd > RIGHT_P) ? RIGHT_P[19:0] : rnd[19:0];
		if (zero_s1) begin
			res = pos_s1 ? RIGHT_S : (nneg_s1 ? -RIGHT_S : '0);
		end else begin
			res = neg_s1 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
		priority if (res > 21'sd32767) begin
			sat = 16'sh7FFF;
		end else if (res < -21'sd32768) begin
			sat = 16'sh8000;
		end else begin
			sat = res[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_s2 <= sat;
		end
	end
endmodule

// File: src/accel_tilt_angles.sv
// Top level of the accelerometer tilt angle pipeline.
// Usage: a sample transfer (sample_valid high, sample_stall low) carries one raw
// signed x, y, z reading. Each sample gives one angle transfer carrying pitch,
// roll and yaw in degrees with ANGLE_FRAC_BITS fraction bits, each
// atan(a / sqrt(b*b + c*c)) of one axis against the other two.
// From sample transfer to angle_valid a sample passes the square and sum
// stages, 31 square root digit cells, one CORDIC cell per step (at most 24),
// two conversion stages and the output register.
// Throughput is one sample per cycle while sample_stall is low; every cell
// holds one sample per lane and hands it to its neighbour each cycle that the chain advances.
// When the receiver stalls, the output register holds its angle and one more
// result lands in a skid register; only then does sample_stall rise and the
// whole chain freeze until the output is taken.
// Reset clears all valid flags, the skid flag among them; data registers are not reset.
module accel_tilt_angles #(
	parameter int ANGLE_FRAC_BITS = 8,
	parameter int CORDIC_STEPS    = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  ata_pkg::sample_t sample,
	output logic             angle_valid,
	input  logic             angle_stall,
	output ata_pkg::angle_t  angle
);
	import ata_pkg::*;

	localparam int NS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
	localparam int NV = 2 + SQ_STEPS + NS + 2;

	logic               adv;
	logic               accept;
	logic [NV-1:0]      v_q;
	sample_t            sample_s1;
	logic [31:0]        sqx_s1, sqy_s1, sqz_s1;
	sqrt_lane_t         lane_s2 [3];
	sqrt_lane_t         sqv [SQ_STEPS+1][3];
	cordic_lane_t       cv [NS+1][3];
	logic signed [15:0] ang [3];
	angle_t             res;
	angle_t             angle_q, skid_q;
	logic               out_v_q, skid_v_q, take;
	logic [31:0]        sum [3];
	logic signed [15:0] num [3];

	assign adv          = !skid_v_q;
	assign sample_stall = skid_v_q;
	assign accept       = sample_valid && !skid_v_q;

	// Valid flag of every stage moves with the chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[NV-2:0], accept};
		end
	end

	// First stage: squares of each axis.
	always_ff @(posedge clk) begin
		if (adv) begin
			sample_s1 <= sample;
			sqx_s1    <= 32'(sample.accel_x * sample.accel_x);
			sqy_s1    <= 32'(sample.accel_y * sample.accel_y);
			sqz_s1    <= 32'(sample.accel_z * sample.accel_z);
		end
	end

	// Second stage: denominators squared and the radicands of the root.
	assign sum[0] = sqy_s1 + sqz_s1;
	assign sum[1] = sqx_s1 + sqz_s1;
	assign sum[2] = sqx_s1 + sqy_s1;
	assign num[0] = sample_s1.accel_x;
	assign num[1] = sample_s1.accel_y;
	assign num[2] = sample_s1.accel_z;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 3; l++) begin
				lane_s2[l].rad  <= {sum[l], 30'b0};
				lane_s2[l].rem  <= '0;
				lane_s2[l].root <= '0;
				lane_s2[l].num  <= num[l];
				lane_s2[l].zero <= (sum[l] == 32'd0);
			end
		end
	end

	// Square root chain, then CORDIC chain, then conversion, per lane.
	for (genvar l = 0; l < 3; l++) begin : g_lane
		assign sqv[0][l] = lane_s2[l];
		for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
			ata_sqrt_cell u_sq (
				.clk (clk),
				.en  (adv),
				.d   (sqv[k][l]),
				.q   (sqv[k+1][l])
			);
		end

		assign cv[0][l].x       = CW'(sqv[SQ_STEPS][l].root);
		assign cv[0][l].y       = {{(CW-31){sqv[SQ_STEPS][l].num[15]}},
			sqv[SQ_STEPS][l].num, 15'b0};
		assign cv[0][l].z       = '0;
		assign cv[0][l].num_neg = sqv[SQ_STEPS][l].num[15];
		assign cv[0][l].num_pos = !sqv[SQ_STEPS][l].num[15]
			&& (sqv[SQ_STEPS][l].num != 16'sd0);
		assign cv[0][l].zero    = sqv[SQ_STEPS][l].zero;

		for (genvar k = 0; k < NS; k++) begin : g_cor
			ata_cordic_cell #(.STEP(k)) u_cor (
				.clk (clk),
				.en  (adv),
				.d   (cv[k][l]),
				.q   (cv[k+1][l])
			);
		end

		ata_post #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_post (
			.clk      (clk),
			.en       (adv),
			.d        (cv[NS][l]),
			.angle_s2 (ang[l])
		);
	end

	assign res.pitch_deg = ang[0];
	assign res.roll_deg  = ang[1];
	assign res.yaw_deg   = ang[2];

	// Output register with one skid entry.
	assign take = out_v_q && !angle_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) begin
				skid_v_q <= 1'b0;
			end
		end else if (v_q[NV-1]) begin
			if (out_v_q && !take) begin
				skid_v_q <= 1'b1;
			end
			out_v_q <= 1'b1;
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				angle_q <= skid_q;
			end
		end else if (v_q[NV-1]) begin
			if (out_v_q && !take) begin
				skid_q <= res;
			end else begin
				angle_q <= res;
			end
		end
	end

	assign angle_valid = out_v_q;
	assign angle       = angle_q;
endmodule

// File: src/ata_checker.sv
// Port checker of the tilt angle block and its binding to the top level.
`include "accel_tilt_angles_macros.svh"

module ata_checker #(
	parameter int ANGLE_FRAC_BITS = 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             sample_valid,
	input logic             sample_stall,
	input ata_pkg::sample_t sample,
	input logic             angle_valid,
	input logic             angle_stall,
	input ata_pkg::angle_t  angle
);
	import ata_pkg::*;

	localparam int RIGHT_I = 90 << ANGLE_FRAC_BITS;
	localparam int LIM_I   = (RIGHT_I > 32767) ? 32767 : RIGHT_I;
	localparam logic signed [16:0] LIM = 17'(LIM_I);

	logic in_range;
	logic unused;

	assign in_range = ($signed({angle.pitch_deg[15], angle.pitch_deg}) <= LIM)
		&& ($signed({angle.pitch_deg[15], angle.pitch_deg}) >= -LIM)
		&& ($signed({angle.roll_deg[15], angle.roll_deg}) <= LIM)
		&& ($signed({angle.roll_deg[15], angle.roll_deg}) >= -LIM)
		&& ($signed({angle.yaw_deg[15], angle.yaw_deg}) <= LIM)
		&& ($signed({angle.yaw_deg[15], angle.yaw_deg}) >= -LIM);
	assign unused = sample_valid ^ (^sample);

	// A stalled result stays on the port unchanged.
	`ATA_ASSERT_NEXT(a_hold, angle_valid && angle_stall, angle_valid && $stable(angle))
	// Every angle lies within a right angle.
	`ATA_ASSERT_NOW(a_range, angle_valid, in_range)
	// The input only stalls behind a waiting result.
	`ATA_ASSERT_NOW(a_stall_needs_out, !angle_valid, !sample_stall)
	// The input stall follows a stalled result at the previous edge.
	`ATA_ASSERT_NOW(a_stall_cause, sample_stall, $past(angle_valid && angle_stall))
endmodule

bind accel_tilt_angles ata_checker #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_ata_checker (.*);

// File: test/accel_tilt_angles_check.sv
// Checker that predicts and compares the tilt angles of every sample transfer.
`timescale 1ns / 100ps

module accel_tilt_angles_check #(
	parameter int ANGLE_FRAC_BITS = 8,
	parameter int CORDIC_STEPS    = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	input  logic             sample_stall,
	input  ata_pkg::sample_t sample,
	input  logic             angle_valid,
	input  logic             angle_stall,
	input  ata_pkg::angle_t  angle,
	output int               failures,
	output int               pending
);

	// atan(2^-i) in radians with 30 fraction bits.
	localparam longint ARCTAN_Q30 [24] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
		64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
		64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
	};
	localparam longint unsigned DEGREES_PER_RADIAN_Q24 = 64'd961263669;

	ata_pkg::angle_t expected_angles [$];

	// Exact integer square root, rounded down.
	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned root;
		longint unsigned b_pos;
		root  = 0;
		b_pos = 64'd1 << 62;
		while (b_pos > v)
			b_pos >>= 2;
		while (b_pos != 0) begin
			if (v >= root + b_pos) begin
				v    = v - (root + b_pos);
				root = (root >> 1) + b_pos;
			end else begin
				root >>= 1;
			end
			b_pos >>= 2;
		end
		return root;
	endfunction

	// Angle of axis a against the plane of b and c, in fixed-point degrees.
	function automatic logic signed [15:0] axis_tilt(input longint a, input longint b,
			input longint c);
		longint          right_angle;
		longint          radius;
		longint          xv, yv, zv, dx, dy, res;
		longint unsigned mag;
		int              shift;
		right_angle = longint'(90) <<< ANGLE_FRAC_BITS;
		shift       = 54 - ANGLE_FRAC_BITS;
		radius      = b * b + c * c;
		if (radius == 0) begin
			res = (a > 0) ? right_angle : ((a < 0) ? -right_angle : 0);
		end else begin
			xv = longint'(int_sqrt(longint'(radius) << 30));
			yv = a * 32768;
			zv = 0;
			for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
				dx = yv >>> i;
				dy = xv >>> i;
				if (yv >= 0) begin
					xv = xv + dx;
					yv = yv - dy;
					zv = zv + ARCTAN_Q30[i];
				end else begin
					xv = xv - dx;
					yv = yv + dy;
					zv = zv - ARCTAN_Q30[i];
				end
			end
			mag = longint'(zv < 0 ? -zv : zv) * DEGREES_PER_RADIAN_Q24;
			mag = (mag + (64'd1 << (shift - 1))) >> shift;
			if (mag > right_angle)
				mag = right_angle;
			res = (zv < 0) ? -longint'(mag) : longint'(mag);
		end
		if (res > 32767)
			res = 32767;
		if (res < -32768)
			res = -32768;
		return res[15:0];
	endfunction

	// Compare one field, allowing one unit of rounding difference.
	function automatic int field_differs(input logic signed [15:0] want,
			input logic signed [15:0] got);
		int diff;
		diff = int'(want) - int'(got);
		return (diff > 1 || diff < -1);
	endfunction

	initial begin
		failures = 0;
		pending  = 0;
	end

	// Predict on each sample transfer and check each angle transfer.
	always @(posedge clk) begin
		ata_pkg::angle_t want;
		longint ax, ay, az;
		if (arst_n) begin
			if (sample_valid && !sample_stall) begin
				ax = sample.accel_x;
				ay = sample.accel_y;
				az = sample.accel_z;
				want.pitch_deg = axis_tilt(ax, ay, az);
				want.roll_deg  = axis_tilt(ay, ax, az);
				want.yaw_deg   = axis_tilt(az, ax, ay);
				expected_angles.push_back(want);
			end
			if (angle_valid && !angle_stall) begin
				if (expected_angles.size() == 0) begin
					$display("%0t: unexpected angle transfer %0d %0d %0d", $time,
						angle.pitch_deg, angle.roll_deg, angle.yaw_deg);
					failures++;
				end else begin
					want = expected_angles.pop_front();
					if (field_differs(want.pitch_deg, angle.pitch_deg) ||
							field_differs(want.roll_deg, angle.roll_deg) ||
							field_differs(want.yaw_deg, angle.yaw_deg)) begin
						$display("%0t: angle mismatch, expected %0d %0d %0d, actual %0d %0d %0d",
							$time, want.pitch_deg, want.roll_deg, want.yaw_deg,
							angle.pitch_deg, angle.roll_deg, angle.yaw_deg);
						failures++;
					end
				end
			end
			pending = expected_angles.size();
		end
	end

endmodule

// File: test/accel_tilt_angles_tb.sv
// Top of the tilt angle testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module accel_tilt_angles_tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN       = 80;

	logic             clk;
	logic             arst_n;
	logic             sample_valid;
	logic             sample_stall;
	ata_pkg::sample_t sample;
	logic             angle_valid;
	logic             angle_stall;
	ata_pkg::angle_t  angle;
	int               failures;
	int               pending;
	int               gap_pct;
	int               stall_pct;
	int               cycles;

	accel_tilt_angles dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.angle_valid  (angle_valid),
		.angle_stall  (angle_stall),
		.angle        (angle)
	);

	accel_tilt_angles_check check (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.angle_valid  (angle_valid),
		.angle_stall  (angle_stall),
		.angle        (angle),
		.failures     (failures),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Random receiver stalls at the rate of the current phase.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			angle_stall <= 1'b0;
		else
			angle_stall <= ($urandom_range(99) < stall_pct);
	end

	// Guard against a hung pipeline.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[accel_tilt_angles] ERROR");
			$finish;
		end
	end

	// Offer one sample, after a random gap, and hold it until it is transferred.
	// During a gap valid is low, so the previous sample is never offered twice.
	task automatic send_sample(input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] z);
		if ($urandom_range(99) < gap_pct) begin
			sample_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < gap_pct);
		end
		sample_valid <= 1'b1;
		sample       <= '{x, y, z};
		do
			@(posedge clk);
		while (sample_stall);
	endtask

	// Random sample: mostly full range, some small, some with zero axes.
	task automatic send_random_sample();
		logic [15:0] v [3];
		int kind;
		kind = $urandom_range(9);
		for (int i = 0; i < 3; i++) begin
			if (kind < 6)
				v[i] = $urandom;
			else if (kind < 8)
				v[i] = 16'($signed($urandom_range(64)) - 32);
			else
				v[i] = ($urandom_range(1) != 0) ? 16'd0 : 16'($urandom);
		end
		send_sample(v[0], v[1], v[2]);
	endtask

	initial begin
		cycles       = 0;
		gap_pct      = 0;
		stall_pct    = 0;
		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample       = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners: zero sample, single axes, extremes and mixed signs.
		send_sample(16'd0, 16'd0, 16'd0);
		send_sample(16'd1, 16'd0, 16'd0);
		send_sample(16'hFFFF, 16'd0, 16'd0);
		send_sample(16'd0, 16'd1, 16'd0);
		send_sample(16'd0, 16'hFFFF, 16'd0);
		send_sample(16'd0, 16'd0, 16'd1);
		send_sample(16'd0, 16'd0, 16'hFFFF);
		send_sample(16'h8000, 16'd0, 16'd0);
		send_sample(16'h7FFF, 16'd0, 16'd0);
		send_sample(16'd0, 16'h8000, 16'd0);
		send_sample(16'd0, 16'd0, 16'h7FFF);
		send_sample(16'h8000, 16'h8000, 16'h8000);
		send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_sample(16'h8000, 16'h7FFF, 16'h8000);
		send_sample(16'h7FFF, 16'h8000, 16'd1);
		send_sample(16'd1, 16'd1, 16'd1);
		send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_sample(16'h5555, 16'hAAAA, 16'h0000);
		send_sample(16'hAAAA, 16'h5555, 16'hFFFF);
		send_sample(16'd1, 16'h7FFF, 16'h8000);
		send_sample(16'h8000, 16'd1, 16'd0);

		// Random phases: none, sender gaps, receiver stalls, both.
		for (int phase = 0; phase < 4; phase++) begin
			gap_pct   = (phase == 1) ? 62 : ((phase == 3) ? 26 : 0);
			stall_pct = (phase == 2) ? 62 : ((phase == 3) ? 26 : 0);
			repeat (132) send_random_sample();
		end
		sample_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (failures == 0)
			$display("[accel_tilt_angles] OK");
		else
			$display("[accel_tilt_angles] ERROR");
		$finish;
	end

endmodule
